// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the WAVE parser.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wpp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpp assertion failed");

// Like WPP_ASSERT_NEXT but also checked while reset is high.
`define WPP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("wpp assertion failed");

`endif

// ----- design/wpp_pkg.sv -----
// Shared types and constants of the WAVE PCM stream parser.
// Depends on nothing; used by the parser core, the top and the checker.
package wpp_pkg;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] FORMAT_PCM = 16'd1;

   localparam logic [7:0] PCM_OFFSET = 8'd128;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] sample_value;
      logic [15:0] channel_count;
      logic [31:0] audio_rate;
      logic [15:0] sample_bits;
      logic [31:0] data_length;
   } wpp_result_type;

endpackage

// ----- design/wpp_req_if.sv -----
// Input channel of the WAVE parser: one file byte per beat.
// Depends on nothing.
interface wpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

// ----- design/wpp_rsp_if.sv -----
// Result channel of the WAVE parser: one sample or header verdict per beat.
// Depends on nothing.
interface wpp_rsp_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  kind;
   logic signed [15:0] sample_value;
   logic        [15:0] channel_count;
   logic        [31:0] audio_rate;
   logic        [15:0] sample_bits;
   logic        [31:0] data_length;

   modport source (output valid, output kind, output sample_value, output channel_count,
                   output audio_rate, output sample_bits, output data_length,
                   input ready);
   modport sink (input valid, input kind, input sample_value, input channel_count,
                 input audio_rate, input sample_bits, input data_length,
                 output ready);
endinterface

// ----- design/wpp_core.sv -----
// Parser state machine: RIFF/WAVE tag check, chunk walk, fmt capture and sample mixing.
// Depends on wpp_pkg. Updates its state on each step and presents the result combinationally.
module wpp_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [7:0]              data_byte,
   input  logic                    start_req,
   output wpp_pkg::wpp_result_type result
);

   localparam logic [3:0] PH_RIFF  = 4'd0;
   localparam logic [3:0] PH_RSIZE = 4'd1;
   localparam logic [3:0] PH_WAVE  = 4'd2;
   localparam logic [3:0] PH_CID   = 4'd3;
   localparam logic [3:0] PH_CSIZE = 4'd4;
   localparam logic [3:0] PH_FMT   = 4'd5;
   localparam logic [3:0] PH_SKIP  = 4'd6;
   localparam logic [3:0] PH_DATA  = 4'd7;
   localparam logic [3:0] PH_IDLE  = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] chunk_ff, chunk_in;
   logic [15:0] format_ff, format_in;
   logic [15:0] chans_ff, chans_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic        fmt_found_ff, fmt_found_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  low_ff, low_in;
   logic        chan_idx_ff, chan_idx_in;
   logic [16:0] mix_ff, mix_in;
   logic        riff_ok_ff, riff_ok_in;
   logic        pad_ff, pad_in;
   logic        hi_ff, hi_in;

   logic        res_valid;
   logic [1:0]  res_kind;
   logic [15:0] res_sample;
   logic [31:0] res_length;

   always_comb begin
      logic [2:0]  frame;
      logic        format_ok;
      logic [15:0] smp;
      logic [1:0]  idx_next;
      logic [16:0] rounded;

      phase_in     = phase_ff;
      count_in     = count_ff;
      tag_in       = tag_ff;
      chunk_in     = chunk_ff;
      format_in    = format_ff;
      chans_in     = chans_ff;
      rate_in      = rate_ff;
      align_in     = align_ff;
      bits_in      = bits_ff;
      fmt_found_in = fmt_found_ff;
      left_in      = left_ff;
      low_in       = low_ff;
      chan_idx_in  = chan_idx_ff;
      mix_in       = mix_ff;
      riff_ok_in   = riff_ok_ff;
      pad_in       = pad_ff;
      hi_in        = hi_ff;
      res_valid    = 1'b0;
      res_kind     = wpp_pkg::KIND_SAMPLE;
      res_sample   = '0;
      res_length   = '0;
      smp          = '0;
      idx_next     = '0;
      rounded      = '0;

      if (start_req) begin
         phase_in     = PH_RIFF;
         count_in     = '0;
         tag_in       = '0;
         chunk_in     = '0;
         format_in    = '0;
         chans_in     = '0;
         rate_in      = '0;
         align_in     = '0;
         bits_in      = '0;
         fmt_found_in = 1'b0;
         left_in      = '0;
         low_in       = '0;
         chan_idx_in  = 1'b0;
         mix_in       = '0;
         riff_ok_in   = 1'b0;
         pad_in       = 1'b0;
         hi_in        = 1'b0;
      end

      // Frame size is only meaningful for the legal formats: 1 or 2 channels of 8 or 16 bits.
      unique case ({chans_in == 16'd2, bits_in == 16'd16})
         2'b00:   frame = 3'd1;
         2'b01:   frame = 3'd2;
         2'b10:   frame = 3'd2;
         default: frame = 3'd4;
      endcase
      format_ok = (format_in == wpp_pkg::FORMAT_PCM) &&
                  (chans_in == 16'd1 || chans_in == 16'd2) &&
                  (rate_in != 32'd0) && (bits_in == 16'd8 || bits_in == 16'd16) &&
                  (align_in == {13'd0, frame});

      unique case (phase_in)
         PH_RIFF: begin
            tag_in   = {tag_in[23:0], data_byte};
            count_in = count_in + 5'd1;
            if (count_in == 5'd4) begin
               riff_ok_in = (tag_in == wpp_pkg::TAG_RIFF);
               count_in   = '0;
               phase_in   = PH_RSIZE;
            end
         end
         PH_RSIZE: begin
            count_in = count_in + 5'd1;
            if (count_in == 5'd4) begin
               count_in = '0;
               phase_in = PH_WAVE;
            end
         end
         PH_WAVE: begin
            tag_in   = {tag_in[23:0], data_byte};
            count_in = count_in + 5'd1;
            if (count_in == 5'd4) begin
               count_in = '0;
               if (!riff_ok_in || tag_in != wpp_pkg::TAG_WAVE) begin
                  phase_in  = PH_IDLE;
                  res_valid = 1'b1;
                  res_kind  = wpp_pkg::KIND_REJECT;
               end else begin
                  phase_in = PH_CID;
               end
            end
         end
         PH_CID: begin
            tag_in   = {tag_in[23:0], data_byte};
            count_in = count_in + 5'd1;
            if (count_in == 5'd4) begin
               count_in = '0;
               chunk_in = '0;
               phase_in = PH_CSIZE;
            end
         end
         PH_CSIZE: begin
            chunk_in = {data_byte, chunk_in[31:8]};
            count_in = count_in + 5'd1;
            if (count_in == 5'd4) begin
               count_in = '0;
               if (tag_in == wpp_pkg::TAG_FMT) begin
                  if (chunk_in < 32'd16) begin
                     phase_in  = PH_IDLE;
                     res_valid = 1'b1;
                     res_kind  = wpp_pkg::KIND_REJECT;
                  end else begin
                     phase_in = PH_FMT;
                  end
               end else if (tag_in == wpp_pkg::TAG_DATA) begin
                  left_in    = chunk_in;
                  res_valid  = 1'b1;
                  res_length = chunk_in;
                  if (!fmt_found_in || !format_ok) begin
                     phase_in = PH_IDLE;
                     res_kind = wpp_pkg::KIND_REJECT;
                  end else begin
                     chan_idx_in = 1'b0;
                     hi_in       = 1'b0;
                     mix_in      = '0;
                     phase_in    = PH_DATA;
                     res_kind    = wpp_pkg::KIND_ACCEPT;
                  end
               end else begin
                  pad_in   = chunk_in[0];
                  phase_in = (chunk_in == 32'd0) ? PH_CID : PH_SKIP;
               end
            end
         end
         PH_FMT: begin
            if (count_in < 5'd2) begin
               format_in = {data_byte, format_in[15:8]};
            end else if (count_in < 5'd4) begin
               chans_in = {data_byte, chans_in[15:8]};
            end else if (count_in < 5'd8) begin
               rate_in = {data_byte, rate_in[31:8]};
            end else if (count_in >= 5'd12 && count_in < 5'd14) begin
               align_in = {data_byte, align_in[15:8]};
            end else if (count_in >= 5'd14) begin
               bits_in = {data_byte, bits_in[15:8]};
            end
            count_in = count_in + 5'd1;
            if (count_in == 5'd16) begin
               fmt_found_in = 1'b1;
               chunk_in     = chunk_in - 32'd16;
               pad_in       = chunk_in[0];
               count_in     = '0;
               phase_in     = (chunk_in == 32'd0) ? PH_CID : PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (chunk_in != 32'd0) begin
               chunk_in = chunk_in - 32'd1;
            end else begin
               pad_in = 1'b0;
            end
            if (chunk_in == 32'd0 && !pad_in) begin
               count_in = '0;
               phase_in = PH_CID;
            end
         end
         PH_DATA: begin
            if (!chan_idx_in && !hi_in && left_in < {29'd0, frame}) begin
               phase_in = PH_IDLE;
            end else begin
               left_in = left_in - 32'd1;
               if (bits_in == 16'd8) begin
                  smp = {data_byte ^ wpp_pkg::PCM_OFFSET, 8'd0};
               end else if (!hi_in) begin
                  low_in = data_byte;
                  hi_in  = 1'b1;
               end else begin
                  smp   = {data_byte, low_in};
                  hi_in = 1'b0;
               end
               if (bits_in == 16'd8 || !hi_in) begin
                  mix_in   = mix_in + {smp[15], smp};
                  idx_next = {1'b0, chan_idx_in} + 2'd1;
                  if ({14'd0, idx_next} >= chans_in) begin
                     // Two channels: add one to a negative sum so the halving truncates toward zero.
                     rounded = mix_in + {16'd0, mix_in[16]};
                     res_sample  = (chans_in == 16'd1) ? mix_in[15:0] : rounded[16:1];
                     mix_in      = '0;
                     chan_idx_in = 1'b0;
                     if (left_in < {29'd0, frame}) begin
                        phase_in = PH_IDLE;
                     end
                     res_valid  = 1'b1;
                     res_kind   = wpp_pkg::KIND_SAMPLE;
                     res_length = left_in;
                  end else begin
                     chan_idx_in = idx_next[0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.valid         = res_valid;
      result.kind          = res_kind;
      result.sample_value  = res_sample;
      result.channel_count = chans_in;
      result.audio_rate    = rate_in;
      result.sample_bits   = bits_in;
      result.data_length   = res_length;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         count_ff     <= '0;
         tag_ff       <= '0;
         chunk_ff     <= '0;
         format_ff    <= '0;
         chans_ff     <= '0;
         rate_ff      <= '0;
         align_ff     <= '0;
         bits_ff      <= '0;
         fmt_found_ff <= 1'b0;
         left_ff      <= '0;
         low_ff       <= '0;
         chan_idx_ff  <= 1'b0;
         mix_ff       <= '0;
         riff_ok_ff   <= 1'b0;
         pad_ff       <= 1'b0;
         hi_ff        <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         tag_ff       <= tag_in;
         chunk_ff     <= chunk_in;
         format_ff    <= format_in;
         chans_ff     <= chans_in;
         rate_ff      <= rate_in;
         align_ff     <= align_in;
         bits_ff      <= bits_in;
         fmt_found_ff <= fmt_found_in;
         left_ff      <= left_in;
         low_ff       <= low_in;
         chan_idx_ff  <= chan_idx_in;
         mix_ff       <= mix_in;
         riff_ok_ff   <= riff_ok_in;
         pad_ff       <= pad_in;
         hi_ff        <= hi_in;
      end
   end

endmodule

// ----- design/wave_pcm_stream_parser.sv -----
// Each accepted byte is held in the input register until the core parses it; its result beat is
// registered in the output register and shown on the result channel from there.
// Throughput: one byte per cycle; a stalled result channel holds the input stage.
// Reset: synchronous, active high; the parser then expects the RIFF tag and no beat is held.
// Depends on wpp_pkg, wpp_req_if, wpp_rsp_if and wpp_core.
module wave_pcm_stream_parser (
   input  logic    clock,
   input  logic    reset,
   wpp_req_if.sink   req_chan,
   wpp_rsp_if.source rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_start_ff, in_start_in;
   logic       stall;
   logic       step_en;

   wpp_pkg::wpp_result_type core_result;
   wpp_pkg::wpp_result_type out_ff, out_in;

   assign stall          = out_ff.valid && !rsp_chan.ready;
   assign step_en        = in_valid_ff && !stall;
   assign req_chan.ready = !in_valid_ff || !stall;

   wpp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .data_byte (in_byte_ff),
      .start_req (in_start_ff),
      .result    (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_start_in = in_start_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.data_byte;
         in_start_in = req_chan.start_req;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end

      out_in = out_ff;
      if (step_en && core_result.valid) begin
         out_in = core_result;
      end else if (rsp_chan.ready) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_ff.valid <= out_in.valid;
      end
      in_byte_ff           <= in_byte_in;
      in_start_ff          <= in_start_in;
      out_ff.kind          <= out_in.kind;
      out_ff.sample_value  <= out_in.sample_value;
      out_ff.channel_count <= out_in.channel_count;
      out_ff.audio_rate    <= out_in.audio_rate;
      out_ff.sample_bits   <= out_in.sample_bits;
      out_ff.data_length   <= out_in.data_length;
   end

   assign rsp_chan.valid         = out_ff.valid;
   assign rsp_chan.kind          = out_ff.kind;
   assign rsp_chan.sample_value  = out_ff.sample_value;
   assign rsp_chan.channel_count = out_ff.channel_count;
   assign rsp_chan.audio_rate    = out_ff.audio_rate;
   assign rsp_chan.sample_bits   = out_ff.sample_bits;
   assign rsp_chan.data_length   = out_ff.data_length;

endmodule

// ----- design/wpp_checker.sv -----
// Port-level checker of the WAVE parser and its bind to the top level.
// Depends on wpp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wpp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_sample_value,
   input logic [15:0] rsp_channel_count,
   input logic [31:0] rsp_audio_rate,
   input logic [15:0] rsp_sample_bits,
   input logic [31:0] rsp_data_length
);

   logic        sample_beat;
   logic        verdict_beat;
   logic        legal_format;
   logic        verdict_kind;
   logic [49:0] beat_fields;

   assign sample_beat  = rsp_valid && rsp_kind == wpp_pkg::KIND_SAMPLE;
   assign verdict_beat = rsp_valid && rsp_kind != wpp_pkg::KIND_SAMPLE;
   assign legal_format = (rsp_channel_count == 16'd1 || rsp_channel_count == 16'd2) &&
                         (rsp_sample_bits == 16'd8 || rsp_sample_bits == 16'd16) &&
                         rsp_audio_rate != 32'd0;
   assign verdict_kind = rsp_kind == wpp_pkg::KIND_ACCEPT || rsp_kind == wpp_pkg::KIND_REJECT;
   assign beat_fields  = {rsp_kind, rsp_sample_value, rsp_data_length};

   // A sample beat only follows an accepted header, so the format is a legal one.
   `WPP_ASSERT_SAME(a_sample_format, clock, reset, sample_beat, legal_format)

   // Header verdicts carry no sample and are either an accept or a reject.
   `WPP_ASSERT_SAME(a_verdict_quiet, clock, reset, verdict_beat, rsp_sample_value == 16'd0 && verdict_kind)

   // A stalled beat keeps its contents.
   `WPP_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(beat_fields))

   // Reset leaves no beat on the result channel.
   `WPP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind wave_pcm_stream_parser wpp_checker u_wpp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_kind          (rsp_chan.kind),
   .rsp_sample_value  (rsp_chan.sample_value),
   .rsp_channel_count (rsp_chan.channel_count),
   .rsp_audio_rate    (rsp_chan.audio_rate),
   .rsp_sample_bits   (rsp_chan.sample_bits),
   .rsp_data_length   (rsp_chan.data_length)
);
